/* src/pgoc_pkg.sv */
// Shared types, constants and helper functions for the per-channel gain and
// offset calibration block. No dependencies; every other file imports it.
`default_nettype none

package pgoc_pkg;

   // Channel table size and the width of an index into it.
   localparam int CHANNELS = 8;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Q16.16 constants.
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   // Two-point divider: |(ahi - alo) * 65536| fits 49 bits, |mhi - mlo| fits 33 bits.
   localparam int NUM_W     = 49;
   localparam int DEN_W     = 33;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   // Largest accepted gain magnitude, 1000.0 in Q16.16.
   localparam logic [NUM_W-1:0] GAIN_LIMIT = NUM_W'(65536000);

   // Packed stream widths.
   localparam int REQ_W = 176;
   localparam int RSP_W = 40;

   typedef enum logic [1:0] {
      OP_APPLY     = 2'd0,
      OP_SET_ZERO  = 2'd1,
      OP_TWO_POINT = 2'd2,
      OP_RESET_ALL = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic div_start;
      logic mul;
      logic commit;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      opcode_type opcode;
      logic       in_range;
      logic       delta_zero;
      logic       div_done;
      logic       gain_ok;
      logic       out_busy;
   } status_type;

   // Q32.32 to Q16.16, round to nearest with ties up.
   function automatic logic signed [47:0] q_round(input logic signed [63:0] p);
      logic signed [63:0] t;
      begin
         t = p + 64'sd32768;
         q_round = t[63:16];
      end
   endfunction

   // Saturate a 49-bit signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
      begin
         if (x > 49'sh0_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
         end else if (x < -49'sh0_8000_0000) begin
            sat32 = 32'sh8000_0000;
         end else begin
            sat32 = x[31:0];
         end
      end
   endfunction

endpackage

`default_nettype wire

/* src/pgoc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle, for the two-point gain.
// Depends on pgoc_pkg.
`default_nettype none

module pgoc_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [pgoc_pkg::NUM_W-1:0]  num_mag,
   input  wire  [pgoc_pkg::DEN_W-1:0]  den_mag,
   output logic                        done,
   output logic [pgoc_pkg::NUM_W-1:0]  quot
);
   import pgoc_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   quot_ff, quot_in;
   logic [DEN_W:0]     rem_sh;
   logic               ge;

   // One shift-and-subtract step.
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_STEPS);
         rem_in  = '0;
         den_in  = den_mag;
         num_in  = num_mag;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   // The done pulse comes only after the last step has finished.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

`default_nettype wire

/* src/pgoc_datapath.sv */
// Datapath: request registers, channel tables, multiplier, divider and result register.
// Depends on pgoc_pkg and pgoc_div.
`default_nettype none

module pgoc_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [pgoc_pkg::REQ_W-1:0]       req_tdata,
   input  pgoc_pkg::cmd_type                cmd,
   output pgoc_pkg::status_type             status,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [pgoc_pkg::RSP_W-1:0]       rsp_tdata
);
   import pgoc_pkg::*;

   // Request fields.
   opcode_type         op_ff;
   logic [7:0]         ch_ff;
   logic signed [31:0] meas_ff, alo_ff, mlo_ff;
   logic signed [32:0] adiff_ff, mdelta_ff;
   logic               tp_ok_ff;

   // Channel tables.
   logic signed [31:0] gain_ff   [CHANNELS];
   logic signed [31:0] offset_ff [CHANNELS];

   logic signed [63:0] prod_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] value_ff;
   logic               ok_ff;

   logic [CH_W-1:0]    idx;
   logic               in_range;
   logic signed [31:0] gain_rd, offset_rd;
   logic signed [48:0] num_s;
   logic [NUM_W-1:0]   num_mag;
   logic [DEN_W-1:0]   den_mag;
   logic               div_done;
   logic [NUM_W-1:0]   quot;
   logic               quot_neg_ff;
   logic signed [31:0] gain_q;
   logic               gain_ok;
   logic signed [31:0] mul_a, mul_b;
   logic signed [47:0] r_prod, r_neg;
   logic signed [31:0] apply_val, zero_off, tp_off;
   logic signed [31:0] value_in;
   logic               ok_in;

   assign idx       = ch_ff[CH_W-1:0];
   assign in_range  = ch_ff < 8'(CHANNELS);
   assign gain_rd   = gain_ff[idx];
   assign offset_rd = offset_ff[idx];

   // Capture the request; the point differences are formed here, exactly.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= opcode_type'(req_tdata[1:0]);
         ch_ff     <= req_tdata[9:2];
         meas_ff   <= req_tdata[41:10];
         alo_ff    <= req_tdata[73:42];
         mlo_ff    <= req_tdata[105:74];
         adiff_ff  <= {req_tdata[137], req_tdata[137:106]} - {req_tdata[73], req_tdata[73:42]};
         mdelta_ff <= {req_tdata[169], req_tdata[169:138]}
                      - {req_tdata[105], req_tdata[105:74]};
      end
   end

   // Divider operands as magnitudes; the quotient sign is kept aside.
   always_comb begin
      num_s   = {adiff_ff, 16'd0};
      num_mag = num_s[48] ? NUM_W'(-num_s) : NUM_W'(num_s);
      den_mag = mdelta_ff[32] ? DEN_W'(-mdelta_ff) : DEN_W'(mdelta_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quot_neg_ff <= adiff_ff[32] ^ mdelta_ff[32];
      end
   end

   pgoc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .done    (div_done),
      .quot    (quot)
   );

   // Signed gain and its range check.
   assign gain_q  = quot_neg_ff ? -$signed(quot[31:0]) : $signed(quot[31:0]);
   assign gain_ok = (quot != '0) && (quot <= GAIN_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ok_ff <= 1'b0;
      end else if (cmd.load) begin
         tp_ok_ff <= 1'b0;
      end else if (div_done && gain_ok) begin
         tp_ok_ff <= 1'b1;
      end
   end

   // Single 32x32 multiplier shared by apply, set zero and two-point.
   always_comb begin
      if (op_ff == OP_TWO_POINT) begin
         mul_a = gain_q;
         mul_b = mlo_ff;
      end else begin
         mul_a = meas_ff;
         mul_b = gain_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Rounding, offset add and saturation for each opcode.
   always_comb begin
      r_prod    = q_round(prod_ff);
      r_neg     = q_round(-prod_ff);
      apply_val = sat32(49'(r_prod) + 49'(offset_rd));
      zero_off  = sat32(49'(r_neg));
      tp_off    = sat32(49'(alo_ff) - 49'(r_prod));
      value_in  = '0;
      ok_in     = 1'b0;
      case (op_ff)
         OP_APPLY: begin
            value_in = in_range ? apply_val : meas_ff;
            ok_in    = in_range;
         end
         OP_SET_ZERO: begin
            ok_in = in_range;
         end
         OP_TWO_POINT: begin
            ok_in = tp_ok_ff;
         end
         OP_RESET_ALL: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Table updates on commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            gain_ff[i]   <= Q_ONE;
            offset_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         case (op_ff)
            OP_SET_ZERO: begin
               if (in_range) begin
                  offset_ff[idx] <= zero_off;
               end
            end
            OP_TWO_POINT: begin
               if (tp_ok_ff) begin
                  gain_ff[idx]   <= gain_q;
                  offset_ff[idx] <= tp_off;
               end
            end
            OP_RESET_ALL: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  gain_ff[i]   <= Q_ONE;
                  offset_ff[i] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         value_ff <= value_in;
         ok_ff    <= ok_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, ok_ff, value_ff};

   assign status.opcode     = op_ff;
   assign status.in_range   = in_range;
   assign status.delta_zero = mdelta_ff == '0;
   assign status.div_done   = div_done;
   assign status.gain_ok    = gain_ok;
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

   // Every committed request shows up as a response in the next cycle.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without response");

endmodule

`default_nettype wire

/* src/pgoc_ctrl.sv */
// Controller state machine: sequences decode, divide, multiply and commit.
// Depends on pgoc_pkg.
`default_nettype none

module pgoc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  pgoc_pkg::status_type  status,
   output pgoc_pkg::cmd_type     cmd
);
   import pgoc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.opcode)
               OP_APPLY, OP_SET_ZERO: begin
                  state_in = ST_MULTIPLY;
               end
               OP_TWO_POINT: begin
                  if (status.in_range && !status.delta_zero) begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIVIDE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = status.gain_ok ? ST_MULTIPLY : ST_FINISH;
            end
         end
         ST_MULTIPLY: begin
            cmd.mul  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted request always goes to decode next.
   a_load_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DECODE)
      else $error("load not followed by decode");

   // Commit never happens while the response register is still held.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.out_busy)
      else $error("commit over a pending response");

endmodule

`default_nettype wire

/* src/per_channel_gain_offset_calibration.sv */
// Top level of the per-channel gain and offset calibration block.
// Depends on pgoc_pkg, pgoc_ctrl and pgoc_datapath.
//
//  Channel  Direction  Payload (low bit first)
//  req_     in         opcode, channel, measured, actual_low, measured_low,
//                      actual_high, measured_high
//  rsp_     out        result_value, accepted
//
// Apply and set zero pass through capture, decode, multiply and commit; reset
// all through capture, decode and commit. A two-point request that reaches the
// 49-step one-bit-per-cycle divider then multiplies and commits, or skips the
// multiply when the gain is refused; one ruled out by channel or zero delta
// goes from decode straight to commit. Reset is synchronous and restores every
// channel to gain 1.0 and offset 0 at once. A held response stalls only the
// commit step; the next request is taken as soon as the previous one commits.
`default_nettype none

module per_channel_gain_offset_calibration (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // opcode[1:0], channel[9:2], measured[41:10], actual_low[73:42],
   // measured_low[105:74], actual_high[137:106], measured_high[169:138]
   input  wire  [pgoc_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // result_value[31:0], accepted[32]
   output logic [pgoc_pkg::RSP_W-1:0]  rsp_tdata
);
   import pgoc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pgoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pgoc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* test/per_channel_gain_offset_calibration_tb.sv */
// Self-checking testbench for the per-channel gain and offset calibration block.
// It predicts every response from its own copy of the gain and offset tables.
// Depends on pgoc_pkg and per_channel_gain_offset_calibration.
`timescale 1ns / 1ps

// Mirrors the calibration tables and keeps the responses still to come.
class calib_scoreboard;
   logic signed [31:0] gain_q[8];
   logic signed [31:0] offset_q[8];
   logic [32:0]        pending[$];
   int                 mismatches;

   function new();
      mismatches = 0;
      restore_tables();
   endfunction

   function void restore_tables();
      for (int i = 0; i < 8; i++) begin
         gain_q[i] = 32'sd65536;
         offset_q[i] = 32'sd0;
      end
   endfunction

   // Round a Q32.32 product to Q16.16, ties toward plus infinity.
   function longint round_q16(longint p);
      longint t;
      t = p + 64'sd32768;
      return t >>> 16;
   endfunction

   function logic signed [31:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // Note one accepted request and queue the response it should cause.
   function void note_request(pgoc_pkg::opcode_type op, logic [7:0] ch,
                              logic signed [31:0] meas, logic signed [31:0] alo,
                              logic signed [31:0] mlo, logic signed [31:0] ahi,
                              logic signed [31:0] mhi);
      logic signed [31:0] value;
      logic               ok;
      longint             delta, g, num;
      bit                 in_range;
      value = 0;
      ok = 0;
      in_range = ch < pgoc_pkg::CHANNELS;
      case (op)
         pgoc_pkg::OP_APPLY: begin
            if (in_range) begin
               value = clip32(round_q16(longint'(meas) * longint'(gain_q[ch]))
                              + longint'(offset_q[ch]));
               ok = 1;
            end else begin
               value = meas;
            end
         end
         pgoc_pkg::OP_SET_ZERO: begin
            if (in_range) begin
               offset_q[ch] = clip32(round_q16(-(longint'(meas) * longint'(gain_q[ch]))));
               ok = 1;
            end
         end
         pgoc_pkg::OP_TWO_POINT: begin
            if (in_range) begin
               delta = longint'(mhi) - longint'(mlo);
               if (delta != 0) begin
                  num = (longint'(ahi) - longint'(alo)) * 64'sd65536;
                  g = num / delta;
                  if (g != 0 && g <= 64'sd65536000 && g >= -64'sd65536000) begin
                     gain_q[ch] = g[31:0];
                     offset_q[ch] = clip32(longint'(alo) - round_q16(g * longint'(mlo)));
                     ok = 1;
                  end
               end
            end
         end
         default: begin
            restore_tables();
            ok = 1;
         end
      endcase
      pending.push_back({ok, value});
   endfunction

   // Compare one response with the oldest expectation.
   function void check_response(logic [39:0] data);
      logic [32:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", $time, data[32:0]);
         mismatches++;
         return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want[31:0]) begin
         $display("%0t: result_value expected %h actual %h", $time, want[31:0], data[31:0]);
         mismatches++;
      end
      if (data[32] !== want[32]) begin
         $display("%0t: accepted expected %b actual %b", $time, want[32], data[32]);
         mismatches++;
      end
   endfunction
endclass

module per_channel_gain_offset_calibration_tb;
   import pgoc_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   calib_scoreboard  board;
   int               idle_pct;
   int               stall_pct;
   int               quiet_cycles;
   bit               sending_done;

   per_channel_gain_offset_calibration u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Send one request, with a random idle gap ahead of it. The valid line
   // stays high after the handshake so back-to-back requests need no gap.
   task automatic send_request(opcode_type op, logic [7:0] ch, logic [31:0] meas,
                               logic [31:0] alo, logic [31:0] mlo,
                               logic [31:0] ahi, logic [31:0] mhi);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, mhi, ahi, mlo, alo, meas, ch, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, ch, meas, alo, mlo, ahi, mhi);
   endtask

   // Random Q16.16 value, often small so that products stay in range.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2000000)) - 1000000);
         2: return 32'($signed($urandom_range(20000)) - 10000);
         default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      endcase
   endfunction

   // Random request, mostly in-range channels and meaningful two-point pairs.
   task automatic send_random();
      opcode_type  op;
      logic [7:0]  ch;
      logic [31:0] mlo, mhi, alo, ahi;
      op = opcode_type'($urandom_range(15) == 0 ? 3 : $urandom_range(2));
      ch = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(CHANNELS - 1));
      mlo = pick_value();
      alo = pick_value();
      case ($urandom_range(4))
         0: mhi = $urandom();
         1: mhi = mlo;
         default: mhi = mlo + 32'($urandom_range(1 << 18) + 1);
      endcase
      ahi = ($urandom_range(3) == 0) ? $urandom()
                                     : alo + 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      send_request(op, ch, pick_value(), alo, mlo, ahi, mhi);
   endtask

   // Receive side: random stalls, each response checked on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("per_channel_gain_offset_calibration_tb: errors");
         $finish;
      end else if (!sending_done || board.pending.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      sending_done = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, each opcode and each rejection path.
      send_request(OP_APPLY, 8'd0, 32'h7FFF_FFFF, 0, 0, 0, 0);
      send_request(OP_APPLY, 8'd7, 32'h8000_0000, 0, 0, 0, 0);
      send_request(OP_APPLY, 8'd8, 32'h1234_5678, 0, 0, 0, 0);
      send_request(OP_APPLY, 8'd255, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(OP_SET_ZERO, 8'd1, 32'h0003_0000, 0, 0, 0, 0);
      send_request(OP_SET_ZERO, 8'd200, 32'h0003_0000, 0, 0, 0, 0);
      send_request(OP_APPLY, 8'd1, 32'h0001_0000, 0, 0, 0, 0);
      // Gain of exactly 1000.0 is taken, then applied to a large value.
      send_request(OP_TWO_POINT, 8'd2, 0, 32'h0000_0000, 32'h0000_0000,
                   32'h03E8_0000, 32'h0001_0000);
      send_request(OP_APPLY, 8'd2, 32'h7FFF_FFFF, 0, 0, 0, 0);
      send_request(OP_APPLY, 8'd2, 32'h8000_0000, 0, 0, 0, 0);
      // Gain just above 1000.0 is refused.
      send_request(OP_TWO_POINT, 8'd3, 0, 0, 0, 32'h03E8_0001, 32'h0001_0000);
      // Zero measured delta is refused.
      send_request(OP_TWO_POINT, 8'd3, 0, 0, 32'h0005_0000, 32'h0009_0000, 32'h0005_0000);
      // Zero actual delta, so a gain of zero, is refused.
      send_request(OP_TWO_POINT, 8'd3, 0, 0, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      send_request(OP_TWO_POINT, 8'd9, 0, 0, 0, 32'h0002_0000, 32'h0001_0000);
      // Widest operands: a negative gain, then a gain above the limit.
      send_request(OP_TWO_POINT, 8'd4, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_TWO_POINT, 8'd5, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_0000);
      send_request(OP_APPLY, 8'd5, 32'h7FFF_FFFF, 0, 0, 0, 0);
      send_request(OP_APPLY, 8'd4, 32'h0001_0000, 0, 0, 0, 0);
      send_request(OP_RESET_ALL, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_APPLY, 8'd5, 32'h0001_0000, 0, 0, 0, 0);

      // Random phases with different idle and stall mixes.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 32 : 71) : 0;
         stall_pct = (phase == 2) ? 71 : ((phase == 3) ? 32 : 0);
         for (int n = 0; n < 470; n++) send_random();
      end
      req_tvalid <= 1'b0;
      sending_done = 1;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("per_channel_gain_offset_calibration_tb: clean");
      end else begin
         $display("per_channel_gain_offset_calibration_tb: errors");
      end
      $finish;
   end
endmodule
